// ===== hdl/msgr_pkg.sv =====
// shared types, constants and helper functions of the sgr mouse report encoder
package msgr_pkg;

   // divider iterations, one quotient bit each
   localparam int DIV_STEPS = 16;
   localparam int COUNT_W   = $clog2(DIV_STEPS);

   // csr address width and register index
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_REPORT_ENABLE = 2'd0,
      REG_CELL_WIDTH    = 2'd1,
      REG_CELL_HEIGHT   = 2'd2
   } reg_index_type;

   localparam logic [7:0] RESET_CELL_WIDTH  = 8'd8;
   localparam logic [7:0] RESET_CELL_HEIGHT = 8'd16;

   // button codes of the report
   localparam logic [7:0] CODE_LEFT       = 8'd0;
   localparam logic [7:0] CODE_RIGHT      = 8'd2;
   localparam logic [7:0] CODE_LEFT_DRAG  = 8'd32;
   localparam logic [7:0] CODE_RIGHT_DRAG = 8'd34;
   localparam logic [7:0] CODE_HOVER      = 8'd35;

   // ascii bytes
   localparam logic [7:0] ASCII_ESC     = 8'h1b;
   localparam logic [7:0] ASCII_LBRACK  = 8'h5b;
   localparam logic [7:0] ASCII_LT      = 8'h3c;
   localparam logic [7:0] ASCII_SEMI    = 8'h3b;
   localparam logic [7:0] ASCII_PRESS   = 8'h4d;
   localparam logic [7:0] ASCII_RELEASE = 8'h6d;
   localparam logic [7:0] ASCII_ZERO    = 8'h30;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_EMIT
   } state_type;

   // byte positions of one report, in sending order
   typedef enum logic [3:0] {
      SLOT_ESC,
      SLOT_LBRACK,
      SLOT_LT,
      SLOT_CODE_H,
      SLOT_CODE_T,
      SLOT_CODE_O,
      SLOT_SEMI_COL,
      SLOT_COL_H,
      SLOT_COL_T,
      SLOT_COL_O,
      SLOT_SEMI_ROW,
      SLOT_ROW_H,
      SLOT_ROW_T,
      SLOT_ROW_O,
      SLOT_FINAL
   } slot_type;

   typedef struct packed {
      logic       report_enable;
      logic [7:0] cell_width;
      logic [7:0] cell_height;
   } cfg_type;

   typedef struct packed {
      logic     accept;
      logic     div_step;
      logic     check;
      logic     emit_load;
      slot_type slot;
   } cmd_type;

   typedef struct packed {
      logic report_needed;
      logic slot_present;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [3:0] h;
      logic [3:0] t;
      logic [3:0] o;
      logic       has_h;
      logic       has_t;
   } dec_type;

   // decimal digits of an 8-bit value, tens by reciprocal multiply (exact below 100)
   function automatic dec_type to_dec(input logic [7:0] v);
      dec_type     d;
      logic [7:0]  r;
      logic [15:0] p;
      logic [7:0]  ones;
      if (v >= 8'd200) begin
         d.h = 4'd2;
         r   = v - 8'd200;
      end else if (v >= 8'd100) begin
         d.h = 4'd1;
         r   = v - 8'd100;
      end else begin
         d.h = 4'd0;
         r   = v;
      end
      p       = {8'd0, r} * 16'd205;
      d.t     = p[14:11];
      ones    = r - ({4'd0, d.t} * 8'd10);
      d.o     = ones[3:0];
      d.has_h = (v >= 8'd100);
      d.has_t = (v >= 8'd10);
      return d;
   endfunction

   function automatic logic [7:0] digit_byte(input logic [3:0] dig);
      return ASCII_ZERO | {4'd0, dig};
   endfunction

endpackage

// ===== hdl/msgr_req_if.sv =====
// input channel: one mouse poll per item
interface msgr_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic        button_left;
   logic        button_right;

   modport source (output valid, output pos_x, output pos_y, output button_left,
                   output button_right, input ready);
   modport sink (input valid, input pos_x, input pos_y, input button_left,
                 input button_right, output ready);
endinterface

// ===== hdl/msgr_rsp_if.sv =====
// result channel: one report byte per item
interface msgr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== hdl/msgr_csr.sv =====
// apb-style configuration registers
module msgr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [msgr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output msgr_pkg::cfg_type               cfg
);

   msgr_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [1:0]        index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign index      = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.report_enable <= 1'b0;
         cfg_ff.cell_width    <= msgr_pkg::RESET_CELL_WIDTH;
         cfg_ff.cell_height   <= msgr_pkg::RESET_CELL_HEIGHT;
      end else if (wr_en) begin
         case (index)
            msgr_pkg::REG_REPORT_ENABLE: cfg_ff.report_enable <= csr_pwdata[0];
            msgr_pkg::REG_CELL_WIDTH:    cfg_ff.cell_width    <= csr_pwdata[7:0];
            msgr_pkg::REG_CELL_HEIGHT:   cfg_ff.cell_height   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         msgr_pkg::REG_REPORT_ENABLE: csr_prdata = {31'd0, cfg_ff.report_enable};
         msgr_pkg::REG_CELL_WIDTH:    csr_prdata = {24'd0, cfg_ff.cell_width};
         msgr_pkg::REG_CELL_HEIGHT:   csr_prdata = {24'd0, cfg_ff.cell_height};
         default:                     csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== hdl/msgr_ctrl.sv =====
// controller: poll intake, divide count, report decision and byte sequencing
module msgr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   report_enable,
   input  msgr_pkg::status_type   status,
   output msgr_pkg::cmd_type      cmd
);

   msgr_pkg::state_type          state_ff, state_in;
   logic [msgr_pkg::COUNT_W-1:0] count_ff, count_in;
   msgr_pkg::slot_type           slot_ff, slot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msgr_pkg::ST_IDLE;
         count_ff <= '0;
         slot_ff  <= msgr_pkg::SLOT_ESC;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         slot_ff  <= slot_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      slot_in       = slot_ff;
      cmd.accept    = 1'b0;
      cmd.div_step  = 1'b0;
      cmd.check     = 1'b0;
      cmd.emit_load = 1'b0;
      cmd.slot      = slot_ff;
      req_ready     = 1'b0;
      case (state_ff)
         msgr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               count_in   = '0;
               if (report_enable) begin
                  state_in = msgr_pkg::ST_DIVIDE;
               end
            end
         end
         msgr_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == msgr_pkg::COUNT_W'(msgr_pkg::DIV_STEPS - 1)) begin
               state_in = msgr_pkg::ST_CHECK;
            end
         end
         msgr_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            slot_in   = msgr_pkg::SLOT_ESC;
            if (status.report_needed) begin
               state_in = msgr_pkg::ST_EMIT;
            end else begin
               state_in = msgr_pkg::ST_IDLE;
            end
         end
         msgr_pkg::ST_EMIT: begin
            // absent digit slots pass without a byte
            if (!status.slot_present || status.out_free) begin
               cmd.emit_load = status.slot_present;
               if (slot_ff == msgr_pkg::SLOT_FINAL) begin
                  state_in = msgr_pkg::ST_IDLE;
               end else begin
                  slot_in = msgr_pkg::slot_type'(slot_ff + 4'd1);
               end
            end
         end
         default: begin
            state_in = msgr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/msgr_dpath.sv =====
// datapath: button edges, two restoring dividers, cell compare, digits, output register
module msgr_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  msgr_pkg::cfg_type    cfg,
   input  msgr_pkg::cmd_type    cmd,
   output msgr_pkg::status_type status,
   input  logic [15:0]          pos_x,
   input  logic [15:0]          pos_y,
   input  logic                 button_left,
   input  logic                 button_right,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           out_byte,
   output logic                 last
);

   logic        prev_left_ff, prev_right_ff;
   logic [7:0]  last_col_ff, last_row_ff;
   logic [15:0] quo_x_ff, quo_y_ff;
   logic [7:0]  rem_x_ff, rem_y_ff;
   logic [7:0]  code_ff;
   logic        release_ff, edge_ff;
   msgr_pkg::dec_type code_dec_ff, col_dec_ff, row_dec_ff;
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;

   logic        lp, lr, rp, rr;
   logic [7:0]  code_in;
   logic        release_in;
   logic [7:0]  div_x, div_y;
   logic [8:0]  trial_x, trial_y;
   logic        bit_x, bit_y;
   logic [7:0]  rem_x_in, rem_y_in;
   logic [7:0]  col, row;
   logic [7:0]  slot_byte;
   logic        slot_last;
   logic        slot_present;

   // edges against the previous poll, priority left press first
   assign lp = button_left && !prev_left_ff;
   assign lr = !button_left && prev_left_ff;
   assign rp = button_right && !prev_right_ff;
   assign rr = !button_right && prev_right_ff;

   always_comb begin
      release_in = 1'b0;
      if (lp) begin
         code_in = msgr_pkg::CODE_LEFT;
      end else if (lr) begin
         code_in    = msgr_pkg::CODE_LEFT;
         release_in = 1'b1;
      end else if (rp) begin
         code_in = msgr_pkg::CODE_RIGHT;
      end else if (rr) begin
         code_in    = msgr_pkg::CODE_RIGHT;
         release_in = 1'b1;
      end else if (button_left) begin
         code_in = msgr_pkg::CODE_LEFT_DRAG;
      end else if (button_right) begin
         code_in = msgr_pkg::CODE_RIGHT_DRAG;
      end else begin
         code_in = msgr_pkg::CODE_HOVER;
      end
   end

   // zero cell size divides by one
   assign div_x = (cfg.cell_width == 8'd0) ? 8'd1 : cfg.cell_width;
   assign div_y = (cfg.cell_height == 8'd0) ? 8'd1 : cfg.cell_height;

   assign trial_x  = {rem_x_ff, quo_x_ff[15]};
   assign trial_y  = {rem_y_ff, quo_y_ff[15]};
   assign bit_x    = (trial_x >= {1'b0, div_x});
   assign bit_y    = (trial_y >= {1'b0, div_y});
   assign rem_x_in = bit_x ? 8'(trial_x - {1'b0, div_x}) : trial_x[7:0];
   assign rem_y_in = bit_y ? 8'(trial_y - {1'b0, div_y}) : trial_y[7:0];

   assign col = quo_x_ff[7:0] + 8'd1;
   assign row = quo_y_ff[7:0] + 8'd1;

   assign status.report_needed = (col != last_col_ff) || (row != last_row_ff) || edge_ff;
   assign status.out_free      = !out_valid_ff || rsp_ready;
   assign status.slot_present  = slot_present;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_left_ff  <= 1'b0;
         prev_right_ff <= 1'b0;
         last_col_ff   <= 8'd0;
         last_row_ff   <= 8'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            prev_left_ff  <= button_left;
            prev_right_ff <= button_right;
         end
         if (cmd.check && status.report_needed) begin
            last_col_ff <= col;
            last_row_ff <= row;
         end
         if (cmd.emit_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         quo_x_ff   <= pos_x;
         quo_y_ff   <= pos_y;
         rem_x_ff   <= 8'd0;
         rem_y_ff   <= 8'd0;
         code_ff    <= code_in;
         release_ff <= release_in;
         edge_ff    <= lp || lr || rp || rr;
      end else if (cmd.div_step) begin
         quo_x_ff <= {quo_x_ff[14:0], bit_x};
         quo_y_ff <= {quo_y_ff[14:0], bit_y};
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
      end
      if (cmd.check) begin
         code_dec_ff <= msgr_pkg::to_dec(code_ff);
         col_dec_ff  <= msgr_pkg::to_dec(col);
         row_dec_ff  <= msgr_pkg::to_dec(row);
      end
      if (cmd.emit_load) begin
         out_byte_ff <= slot_byte;
         out_last_ff <= slot_last;
      end
   end

   always_comb begin
      slot_last    = 1'b0;
      slot_present = 1'b1;
      case (cmd.slot)
         msgr_pkg::SLOT_ESC:      slot_byte = msgr_pkg::ASCII_ESC;
         msgr_pkg::SLOT_LBRACK:   slot_byte = msgr_pkg::ASCII_LBRACK;
         msgr_pkg::SLOT_LT:       slot_byte = msgr_pkg::ASCII_LT;
         msgr_pkg::SLOT_CODE_H: begin
            slot_byte    = msgr_pkg::digit_byte(code_dec_ff.h);
            slot_present = code_dec_ff.has_h;
         end
         msgr_pkg::SLOT_CODE_T: begin
            slot_byte    = msgr_pkg::digit_byte(code_dec_ff.t);
            slot_present = code_dec_ff.has_t;
         end
         msgr_pkg::SLOT_CODE_O:   slot_byte = msgr_pkg::digit_byte(code_dec_ff.o);
         msgr_pkg::SLOT_SEMI_COL: slot_byte = msgr_pkg::ASCII_SEMI;
         msgr_pkg::SLOT_COL_H: begin
            slot_byte    = msgr_pkg::digit_byte(col_dec_ff.h);
            slot_present = col_dec_ff.has_h;
         end
         msgr_pkg::SLOT_COL_T: begin
            slot_byte    = msgr_pkg::digit_byte(col_dec_ff.t);
            slot_present = col_dec_ff.has_t;
         end
         msgr_pkg::SLOT_COL_O:    slot_byte = msgr_pkg::digit_byte(col_dec_ff.o);
         msgr_pkg::SLOT_SEMI_ROW: slot_byte = msgr_pkg::ASCII_SEMI;
         msgr_pkg::SLOT_ROW_H: begin
            slot_byte    = msgr_pkg::digit_byte(row_dec_ff.h);
            slot_present = row_dec_ff.has_h;
         end
         msgr_pkg::SLOT_ROW_T: begin
            slot_byte    = msgr_pkg::digit_byte(row_dec_ff.t);
            slot_present = row_dec_ff.has_t;
         end
         msgr_pkg::SLOT_ROW_O:    slot_byte = msgr_pkg::digit_byte(row_dec_ff.o);
         msgr_pkg::SLOT_FINAL: begin
            slot_byte = release_ff ? msgr_pkg::ASCII_RELEASE : msgr_pkg::ASCII_PRESS;
            slot_last = 1'b1;
         end
         default: begin
            slot_byte    = msgr_pkg::ASCII_ESC;
            slot_present = 1'b0;
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign last      = out_last_ff;

endmodule

// ===== hdl/mouse_sgr_report_encoder.sv =====
// top level of the sgr 1006 mouse report encoder
// Each accepted poll (pixel x/y, left/right button levels) is turned into an
// xterm SGR 1006 report sent one ASCII byte per item on the rsp channel:
// ESC [ < code ; col ; row then M (press or motion) or m (release), with last
// set on that final byte. A poll is taken only while the controller is idle.
// With reporting off a poll is taken in idle and only the button levels are
// kept. With reporting on, x and y go through two restoring dividers side by
// side, one quotient bit per cycle, then the check state does the cell
// compare and digit split; an unchanged cell with no button edge ends there.
// A report then walks 15 byte slots, one per cycle while the sink is ready,
// absent leading-zero digits passing without a byte; a stalled sink holds
// the slot walk. The last byte sits in the output register while the next
// poll is already taken.
module mouse_sgr_report_encoder (
   input  logic                            clock,
   input  logic                            reset,
   msgr_req_if.sink                        req_ch,
   msgr_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [msgr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   msgr_pkg::cfg_type    cfg;
   msgr_pkg::cmd_type    cmd;
   msgr_pkg::status_type status;
   logic                 req_ready;
   logic                 rsp_valid;
   logic [7:0]           out_byte;
   logic                 out_last;

   // configuration registers
   msgr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: idle, divide, check, emit
   msgr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ready),
      .report_enable (cfg.report_enable),
      .status        (status),
      .cmd           (cmd)
   );

   // dividers, edge logic, digits and output register
   msgr_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .status       (status),
      .pos_x        (req_ch.pos_x),
      .pos_y        (req_ch.pos_y),
      .button_left  (req_ch.button_left),
      .button_right (req_ch.button_right),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ch.ready),
      .out_byte     (out_byte),
      .last         (out_last)
   );

   assign req_ch.ready    = req_ready;
   assign rsp_ch.valid    = rsp_valid;
   assign rsp_ch.out_byte = out_byte;
   assign rsp_ch.last     = out_last;

   // a report ends long before the next one can start its first byte
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.last |=> !rsp_ch.valid)
      else $error("byte item right after the final byte of a report");

   // an enabled poll keeps the intake closed while the dividers run
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && cfg.report_enable |=> !req_ch.ready)
      else $error("poll intake open during divide");

   // a byte is only loaded into a free output register
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("output byte overwritten before it was taken");

endmodule
